// ===== hw/rtl/tlbsc_pkg.sv =====
// Shared types, codes and sizes for the second-chance translation buffer refill core.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none
package tlbsc_pkg;

  localparam int TLB_SLOTS  = 4;
  localparam int SLOT_BITS  = 2;
  localparam int VPN_BITS   = 10;
  localparam int FRAME_BITS = 8;
  localparam int PCNT_BITS  = 11;

  localparam logic [PCNT_BITS-1:0] PAGE_COUNT_RESET = 11'd1024;

  // Input item modes
  localparam logic [1:0] MODE_REFILL  = 2'd0;
  localparam logic [1:0] MODE_ACCESS  = 2'd1;
  localparam logic [1:0] MODE_SAVE    = 2'd2;
  localparam logic [1:0] MODE_RESTORE = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_WB   = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  // Datapath operations issued by the controller
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_BAD       = 3'd1;
  localparam logic [2:0] OP_FILL_FREE = 3'd2;
  localparam logic [2:0] OP_ACCESS    = 3'd3;
  localparam logic [2:0] OP_RESTORE   = 3'd4;
  localparam logic [2:0] OP_SWEEP     = 3'd5;
  localparam logic [2:0] OP_SAVE      = 3'd6;
  localparam logic [2:0] OP_SAVE_DONE = 3'd7;

  typedef struct packed {
    logic [1:0]            mode;
    logic [VPN_BITS-1:0]   vpn;
    logic [FRAME_BITS-1:0] entry_frame;
    logic                  entry_valid;
    logic                  entry_use;
    logic                  entry_dirty;
    logic                  entry_read_only;
    logic [SLOT_BITS-1:0]  access_slot;
    logic                  access_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [SLOT_BITS-1:0] slot;
    logic [VPN_BITS-1:0]  out_vpn;
    logic                 out_use;
    logic                 out_dirty;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic [2:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bad_page;
    logic       any_free;
    logic       hand_use;
    logic       save_last;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tlbsc_ctrl.sv =====
// Controller state machine: sequences refill sweeps and save scans over the datapath.
// Depends on tlbsc_pkg for command/status structs and operation codes.
`timescale 1ns / 1ps
`default_nettype none
module tlbsc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tlbsc_pkg::dp_status_t status,
  output tlbsc_pkg::dp_cmd_t        cmd
);
  import tlbsc_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_SWEEP     = 3'd2;
  localparam logic [2:0] S_SAVE      = 3'd3;
  localparam logic [2:0] S_SAVE_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    in_ready    = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.mode)
          MODE_REFILL: begin
            if (status.out_free) begin
              if (status.bad_page) begin
                cmd.op     = OP_BAD;
                state_next = S_IDLE;
              end else if (status.any_free) begin
                cmd.op     = OP_FILL_FREE;
                state_next = S_IDLE;
              end else begin
                state_next = S_SWEEP;
              end
            end
          end
          MODE_ACCESS: begin
            if (status.out_free) begin
              cmd.op     = OP_ACCESS;
              state_next = S_IDLE;
            end
          end
          MODE_SAVE: begin
            state_next = S_SAVE;
          end
          MODE_RESTORE: begin
            if (status.out_free) begin
              cmd.op     = OP_RESTORE;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SWEEP: begin
        // one slot visit per beat; a clear use bit ends the sweep
        if (status.out_free) begin
          cmd.op = OP_SWEEP;
          if (!status.hand_use) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SAVE: begin
        if (status.out_free) begin
          cmd.op = OP_SAVE;
          if (status.save_last) begin
            state_next = S_SAVE_DONE;
          end
        end
      end
      S_SAVE_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_SAVE_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tlbsc_dp.sv =====
// Datapath: slot store, clock hand, scan index, page-count register and result register.
// Depends on tlbsc_pkg; driven by commands from tlbsc_ctrl, the input item and the page-count config.
`timescale 1ns / 1ps
`default_nettype none
module tlbsc_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tlbsc_pkg::in_item_t              in_data,
  input  wire logic                             cfg_we,
  input  wire logic [tlbsc_pkg::PCNT_BITS-1:0]  cfg_wdata,
  input  wire tlbsc_pkg::dp_cmd_t               cmd,
  output tlbsc_pkg::dp_status_t                 status,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tlbsc_pkg::out_item_t                  out_data
);
  import tlbsc_pkg::*;

  logic [PCNT_BITS-1:0]  page_count;
  in_item_t              item;
  logic [SLOT_BITS-1:0]  hand;
  logic [SLOT_BITS-1:0]  idx;
  logic [SLOT_BITS-1:0]  hand_next;
  logic [SLOT_BITS-1:0]  free_idx;

  logic [VPN_BITS-1:0]   slot_vpn   [TLB_SLOTS];
  logic [FRAME_BITS-1:0] slot_frame [TLB_SLOTS];
  logic [TLB_SLOTS-1:0]  slot_valid;
  logic [TLB_SLOTS-1:0]  slot_use;
  logic [TLB_SLOTS-1:0]  slot_dirty;
  logic [TLB_SLOTS-1:0]  slot_read_only;

  logic                  emit;
  out_item_t             res;
  logic                  load_en;
  logic [SLOT_BITS-1:0]  load_idx;
  logic                  use_clr;
  logic                  acc_en;
  logic                  clear_all;

  always_comb begin
    free_idx = '0;
    for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  assign hand_next = (hand == SLOT_BITS'(TLB_SLOTS - 1)) ? '0 : hand + 1'b1;

  assign status.mode      = item.mode;
  assign status.bad_page  = ({1'b0, item.vpn} >= page_count);
  assign status.any_free  = ~&slot_valid;
  assign status.hand_use  = slot_use[hand];
  assign status.save_last = (idx == SLOT_BITS'(TLB_SLOTS - 1));
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    emit      = 1'b0;
    res       = '0;
    load_en   = 1'b0;
    load_idx  = free_idx;
    use_clr   = 1'b0;
    acc_en    = 1'b0;
    clear_all = 1'b0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_BAD: begin
        emit        = 1'b1;
        res.kind    = KIND_BAD;
        res.out_vpn = item.vpn;
        res.last    = 1'b1;
      end
      OP_FILL_FREE: begin
        emit          = 1'b1;
        load_en       = 1'b1;
        res.kind      = KIND_FILL;
        res.slot      = free_idx;
        res.out_vpn   = item.vpn;
        res.out_use   = item.entry_use;
        res.out_dirty = item.entry_dirty;
        res.last      = 1'b1;
      end
      OP_ACCESS: begin
        emit     = 1'b1;
        acc_en   = slot_valid[item.access_slot];
        res.kind = KIND_DONE;
        res.slot = item.access_slot;
        res.last = 1'b1;
      end
      OP_RESTORE, OP_SAVE_DONE: begin
        emit      = 1'b1;
        clear_all = 1'b1;
        res.kind  = KIND_DONE;
        res.last  = 1'b1;
      end
      OP_SWEEP: begin
        emit          = 1'b1;
        res.slot      = hand;
        res.out_vpn   = slot_vpn[hand];
        res.out_dirty = slot_dirty[hand];
        if (slot_use[hand]) begin
          use_clr     = 1'b1;
          res.kind    = KIND_WB;
          res.out_use = 1'b1;
        end else begin
          load_en  = 1'b1;
          load_idx = hand;
          res.kind = KIND_FILL;
          res.last = 1'b1;
        end
      end
      OP_SAVE: begin
        emit          = slot_valid[idx];
        res.kind      = KIND_WB;
        res.slot      = idx;
        res.out_vpn   = slot_vpn[idx];
        res.out_use   = slot_use[idx];
        res.out_dirty = slot_dirty[idx];
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= PAGE_COUNT_RESET;
      slot_valid <= '0;
      hand       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_count <= cfg_wdata;
      end
      if (clear_all) begin
        slot_valid <= '0;
      end else if (load_en) begin
        slot_valid[load_idx] <= item.entry_valid;
      end
      if (cmd.op == OP_SWEEP) begin
        hand <= hand_next;
      end else if (cmd.op == OP_RESTORE) begin
        hand <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      idx  <= '0;
    end else if (cmd.op == OP_SAVE) begin
      idx <= idx + 1'b1;
    end
    if (load_en) begin
      slot_vpn[load_idx]       <= item.vpn;
      slot_frame[load_idx]     <= item.entry_frame;
      slot_use[load_idx]       <= item.entry_use;
      slot_dirty[load_idx]     <= item.entry_dirty;
      slot_read_only[load_idx] <= item.entry_read_only;
    end
    if (use_clr) begin
      slot_use[hand] <= 1'b0;
    end
    if (acc_en) begin
      slot_use[item.access_slot] <= 1'b1;
      if (item.access_write) begin
        slot_dirty[item.access_slot] <= 1'b1;
      end
    end
    if (emit) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tlb_second_chance_refill_core.sv =====
// Top level of the second-chance translation buffer refill core.
// Depends on tlbsc_pkg, tlbsc_ctrl and tlbsc_dp.
`timescale 1ns / 1ps
`default_nettype none
// A four-slot translation buffer refilled by the clock (second-chance) policy.
// One input beat is taken at a time and answers with one to five result beats,
// the final one flagged by last. A refill takes the lowest invalid slot; when
// all slots are valid the clock hand visits slots, one per cycle while the
// sink takes results, clearing set use bits (each reported as a page-table
// writeback) until it reaches a slot with a clear use bit, which is evicted
// and reloaded. Refills of a page at or above page_count return a single
// bad-page result and change nothing. Access beats mark use/dirty on a valid
// slot; save writes back every valid slot and invalidates all; restore
// invalidates all and parks the hand at slot zero.
// Each item is taken in idle and then decoded. A bad page, a refill into a
// free slot, an access and a restore issue their one result from decode. A
// refill into a full buffer issues one result per hand visit (1 to 5 visits).
// A save scans all four slots, whether valid or not, then issues the done
// beat. The result register is the only output stage, so a stalled sink
// holds the controller at its next result.
// Write page_count (cfg_we/cfg_wdata) only while the core is idle.
module tlb_second_chance_refill_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tlbsc_pkg::in_item_t              in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tlbsc_pkg::out_item_t                  out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tlbsc_pkg::PCNT_BITS-1:0]  cfg_wdata
);
  import tlbsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequence the item: decode, sweep or scan, then drop back to idle
  tlbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold slot state and the result register
  tlbsc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A result is only loaded when the result register is free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE && cmd.op != OP_SAVE) |-> status.out_free)
    else $error("result loaded over a pending beat");

  // Taking an input beat closes the input side on the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A sweep visit that finds a clear use bit ends the refill.
  a_victim_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SWEEP && !status.hand_use) |=> (in_ready && out_valid && out_data.last))
    else $error("victim visit did not finish the refill");

endmodule
`default_nettype wire
